// ===== hw/rtl/uart_tx_fifo_flow_control_assert.svh =====
// Assertion macros used by the transmit queue ring RTL.
`ifndef UART_TX_FIFO_FLOW_CONTROL_ASSERT_SVH
`define UART_TX_FIFO_FLOW_CONTROL_ASSERT_SVH

// Property checked on every rising clock edge outside reset.
`define UTXFC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition that must never hold outside reset.
`define UTXFC_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

// ===== hw/rtl/utxfc_pkg.sv =====
`timescale 1ns / 1ps

package utxfc_pkg;

  localparam int DEFAULT_BUF_DEPTH = 256;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_FLOW_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CTS_LEVEL = 1'b1;

  localparam logic [2:0] OP_ENQUEUE = 3'd0;
  localparam logic [2:0] OP_DRAIN   = 3'd1;
  localparam logic [2:0] OP_RECEIVE = 3'd2;
  localparam logic [2:0] OP_CLEAR   = 3'd3;
  localparam logic [2:0] OP_SET_XON = 3'd4;

  localparam logic [2:0] MODE_DISABLED   = 3'd0;
  localparam logic [2:0] MODE_RTS_CTS    = 3'd1;
  localparam logic [2:0] MODE_XON_NORMAL = 3'd2;
  localparam logic [2:0] MODE_AUTOOFF    = 3'd3;
  localparam logic [2:0] MODE_MANUAL     = 3'd4;

  localparam logic [7:0] XON_CHAR  = 8'd17;
  localparam logic [7:0] XOFF_CHAR = 8'd19;
  localparam logic [7:0] CTRL_C    = 8'd3;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] data_byte;
    logic       cts_level;
    logic       tx_room;
    logic       tx_empty;
    logic       rx_idle;
  } item_t;

  typedef struct packed {
    logic clear;
    logic push;
    logic pop;
  } ring_req_t;

  typedef struct packed {
    logic empty;
    logic full;
  } ring_sts_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       accepted;
    logic       xon_next;
    logic       halted;
    logic       cancelled;
    logic       rx_interrupt;
  } result_t;

endpackage

// ===== hw/rtl/utxfc_ram.sv =====
`timescale 1ns / 1ps

module utxfc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/utxfc_flow.sv =====
`timescale 1ns / 1ps

module utxfc_flow (
  input  utxfc_pkg::item_t     item,
  input  logic [2:0]           flow_mode,
  input  logic                 cts_active,
  input  logic                 xon,
  input  utxfc_pkg::ring_sts_t sts,
  input  logic [7:0]           rd_data,
  output utxfc_pkg::ring_req_t req,
  output utxfc_pkg::result_t   res
);

  import utxfc_pkg::*;

  logic is_rts;
  logic is_xon;
  logic cts_ok;
  logic allowed_pre;
  logic direct;

  assign is_rts = (flow_mode == MODE_RTS_CTS);
  assign is_xon = (flow_mode == MODE_XON_NORMAL) || (flow_mode == MODE_AUTOOFF) ||
                  (flow_mode == MODE_MANUAL);
  assign cts_ok = (item.cts_level == cts_active);
  assign allowed_pre = is_rts ? cts_ok : (is_xon ? xon : 1'b1);

  always_comb begin
    req = '0;
    res = '0;
    res.xon_next = xon;
    direct = 1'b0;
    unique case (item.op)
      OP_ENQUEUE: begin
        if (sts.empty) begin
          priority if (is_rts) begin
            direct = cts_ok;
          end else if (is_xon) begin
            direct = item.tx_empty && item.rx_idle && xon;
          end else begin
            direct = item.tx_room && item.rx_idle;
          end
        end
        req.push = !direct && !sts.full;
        res.accepted = direct || req.push;
        res.tx_valid = direct;
        if (direct) begin
          res.tx_byte = item.data_byte;
        end
      end
      OP_DRAIN: begin
        req.pop = !sts.empty && item.tx_room && allowed_pre;
        res.tx_valid = req.pop;
        if (req.pop) begin
          res.tx_byte = rd_data;
        end
      end
      OP_RECEIVE: begin
        priority if (item.data_byte == CTRL_C) begin
          res.rx_interrupt = 1'b1;
        end else if (flow_mode == MODE_XON_NORMAL) begin
          priority if (!xon && item.data_byte == XON_CHAR) begin
            res.xon_next = 1'b1;
          end else if (xon && item.data_byte == XOFF_CHAR) begin
            res.xon_next = 1'b0;
          end else begin
            res.xon_next = xon;
          end
        end else if (flow_mode == MODE_AUTOOFF || flow_mode == MODE_MANUAL) begin
          res.xon_next = !xon && (item.data_byte == XON_CHAR);
        end else begin
          res.xon_next = xon;
        end
      end
      OP_CLEAR: begin
        req.clear = 1'b1;
      end
      OP_SET_XON: begin
        res.xon_next = item.data_byte[0];
      end
      default: begin
      end
    endcase
    res.halted = !(is_rts ? cts_ok : (is_xon ? res.xon_next : 1'b1));
    res.cancelled = is_rts && !cts_ok;
  end

endmodule

// ===== hw/rtl/utxfc_ring.sv =====
`timescale 1ns / 1ps

module utxfc_ring #(
  parameter int DEPTH = utxfc_pkg::DEFAULT_BUF_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  utxfc_pkg::ring_req_t req,
  input  logic [7:0]           wr_data,
  output utxfc_pkg::ring_sts_t sts,
  output logic [7:0]           rd_data,
  output logic [7:0]           free_after
);

  import utxfc_pkg::*;

  `include "uart_tx_fifo_flow_control_assert.svh"

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CW = (PTR_W > 8) ? PTR_W : 8;
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  logic [PTR_W-1:0] rp, rp_next;
  logic [PTR_W-1:0] wp, wp_next;
  logic [PTR_W-1:0] used, used_next;
  logic [CW-1:0]    free_w;
  logic             we;
  logic [7:0]       ram_q;
  logic             byp_hit;
  logic [7:0]       byp_data;

  function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
    return (p == LAST) ? '0 : p + PTR_W'(1);
  endfunction

  assign sts.empty = (used == '0);
  assign sts.full  = (used == LAST);
  assign we = en && req.push;

  always_comb begin
    rp_next = rp;
    wp_next = wp;
    used_next = used;
    if (en) begin
      if (req.clear) begin
        wp_next = rp;
        used_next = '0;
      end else if (req.push) begin
        wp_next = bump(wp);
        used_next = used + PTR_W'(1);
      end else if (req.pop) begin
        rp_next = bump(rp);
        used_next = used - PTR_W'(1);
      end
    end
  end

  assign free_w = CW'(DEPTH - 1) - CW'(used_next);
  assign free_after = (free_w > CW'(255)) ? 8'hFF : free_w[7:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      rp <= '0;
      wp <= '0;
      used <= '0;
      byp_hit <= 1'b0;
    end else begin
      rp <= rp_next;
      wp <= wp_next;
      used <= used_next;
      byp_hit <= we && (wp == rp_next);
    end
  end

  always_ff @(posedge clk) begin
    byp_data <= wr_data;
  end

  utxfc_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(wp),
    .wdata(wr_data),
    .raddr(rp_next),
    .rdata(ram_q)
  );

  assign rd_data = byp_hit ? byp_data : ram_q;

  `UTXFC_ASSERT(a_no_push_full, en && req.push |-> !sts.full, "push into full ring")
  `UTXFC_ASSERT(a_no_pop_empty, en && req.pop |-> !sts.empty, "pop from empty ring")
  `UTXFC_ASSERT(a_clear_empties, en && req.clear |=> sts.empty, "ring not empty after clear")
  `UTXFC_NEVER(a_ptr_count, sts.empty != (rp == wp), "count and pointers disagree")

endmodule

// ===== hw/rtl/uart_tx_fifo_flow_control.sv =====
`timescale 1ns / 1ps
// Each item is held in an input register, and its result in a result register.
// Throughput: one item per cycle while out_stall does not hold a valid result,
// with at most one ring pointer update per item.
// Reset: pointers and fill count to zero, XON on, flow_mode and
// cts_active to zero. Buffer contents are not cleared.
module uart_tx_fifo_flow_control #(
  parameter int BUF_DEPTH = utxfc_pkg::DEFAULT_BUF_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [utxfc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [utxfc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [2:0]                     op,
  input  logic [7:0]                     data_byte,
  input  logic                           cts_level,
  input  logic                           tx_room,
  input  logic                           tx_empty,
  input  logic                           rx_idle,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           tx_valid,
  output logic [7:0]                     tx_byte,
  output logic                           accepted,
  output logic [7:0]                     free_count,
  output logic                           xon_now,
  output logic                           halted,
  output logic                           cancelled,
  output logic                           rx_interrupt
);

  import utxfc_pkg::*;

  logic [2:0] flow_mode;
  logic       cts_active;
  logic       xon;
  item_t      in_q;
  logic       in_full;
  logic       adv;
  logic       fire;
  ring_req_t  req;
  ring_sts_t  sts;
  result_t    res;
  result_t    res_q;
  logic [7:0] rd_data;
  logic [7:0] free_after;
  logic [7:0] free_q;

  assign adv = !out_valid || !out_stall;
  assign fire = in_full && adv;
  assign in_stall = in_full && !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      flow_mode <= MODE_DISABLED;
      cts_active <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_FLOW_MODE: flow_mode <= cfg_data;
        REG_CTS_LEVEL: cts_active <= cfg_data[0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
      out_valid <= 1'b0;
      xon <= 1'b1;
    end else begin
      if (in_valid && !in_stall) begin
        in_full <= 1'b1;
      end else if (fire) begin
        in_full <= 1'b0;
      end
      if (fire) begin
        out_valid <= 1'b1;
        xon <= res.xon_next;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_q <= '{op: op, data_byte: data_byte, cts_level: cts_level, tx_room: tx_room,
                tx_empty: tx_empty, rx_idle: rx_idle};
    end
    if (fire) begin
      res_q <= res;
      free_q <= free_after;
    end
  end

  utxfc_flow u_flow (
    .item      (in_q),
    .flow_mode (flow_mode),
    .cts_active(cts_active),
    .xon       (xon),
    .sts       (sts),
    .rd_data   (rd_data),
    .req       (req),
    .res       (res)
  );

  utxfc_ring #(
    .DEPTH(BUF_DEPTH)
  ) u_ring (
    .clk       (clk),
    .rst       (rst),
    .en        (fire),
    .req       (req),
    .wr_data   (in_q.data_byte),
    .sts       (sts),
    .rd_data   (rd_data),
    .free_after(free_after)
  );

  assign tx_valid     = res_q.tx_valid;
  assign tx_byte      = res_q.tx_byte;
  assign accepted     = res_q.accepted;
  assign free_count   = free_q;
  assign xon_now      = res_q.xon_next;
  assign halted       = res_q.halted;
  assign cancelled    = res_q.cancelled;
  assign rx_interrupt = res_q.rx_interrupt;

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
  import utxfc_pkg::*;

  localparam int DEPTH = 256;
  localparam int HOLD_LEN = 300;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;
  localparam logic [2:0] MODE_SPARE_LO = 3'd5;
  localparam logic [2:0] MODE_SPARE_HI = 3'd7;

  typedef struct {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       accepted;
    logic [7:0] free_count;
    logic       xon_now;
    logic       halted;
    logic       cancelled;
    logic       rx_interrupt;
  } tx_status_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] op = OP_ENQUEUE;
  logic [7:0] data_byte = 8'd0;
  logic cts_level = 1'b0;
  logic tx_room = 1'b0;
  logic tx_empty = 1'b0;
  logic rx_idle = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic tx_valid;
  logic [7:0] tx_byte;
  logic accepted;
  logic [7:0] free_count;
  logic xon_now;
  logic halted;
  logic cancelled;
  logic rx_interrupt;

  uart_tx_fifo_flow_control #(.BUF_DEPTH(DEPTH)) dut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .op(op), .data_byte(data_byte), .cts_level(cts_level),
    .tx_room(tx_room), .tx_empty(tx_empty), .rx_idle(rx_idle),
    .out_valid(out_valid), .out_stall(out_stall),
    .tx_valid(tx_valid), .tx_byte(tx_byte), .accepted(accepted),
    .free_count(free_count), .xon_now(xon_now), .halted(halted),
    .cancelled(cancelled), .rx_interrupt(rx_interrupt)
  );

  // predictor state
  logic [7:0] ring [DEPTH];
  logic [7:0] rd_ptr;
  logic [7:0] wr_ptr;
  logic       xon;
  logic [2:0] mode;
  logic       cts_act;

  item_t send_q[$];
  tx_status_t tx_expect_q[$];
  item_t drive_item;
  logic in_taken = 1'b0;
  int items_queued = 0;
  int items_taken = 0;
  int errors = 0;
  int cycles = 0;
  int send_idle_pct = 38;
  int recv_idle_pct = 38;
  int holds_wanted = 0;
  int holds_done = 0;
  int hold_left = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic logic xon_mode();
    return mode >= MODE_XON_NORMAL && mode <= MODE_MANUAL;
  endfunction

  function automatic logic send_ok(logic cts);
    if (mode == MODE_RTS_CTS) return cts == cts_act;
    if (xon_mode()) return xon;
    return 1'b1;
  endfunction

  function automatic tx_status_t step_tx_queue(item_t it);
    tx_status_t r;
    logic direct;
    logic [7:0] wr_next;
    r = '{default: '0};
    direct = 1'b0;
    wr_next = wr_ptr + 8'd1;
    case (it.op)
      OP_ENQUEUE: begin
        if (rd_ptr == wr_ptr) begin
          if (mode == MODE_RTS_CTS) direct = send_ok(it.cts_level);
          else if (xon_mode()) direct = it.tx_empty && it.rx_idle && xon;
          else direct = it.tx_room && it.rx_idle;
        end
        if (direct) begin
          r.tx_valid = 1'b1;
          r.tx_byte = it.data_byte;
          r.accepted = 1'b1;
        end else if (wr_next != rd_ptr) begin
          ring[wr_ptr] = it.data_byte;
          wr_ptr = wr_next;
          r.accepted = 1'b1;
        end
      end
      OP_DRAIN: begin
        if (rd_ptr != wr_ptr && it.tx_room && send_ok(it.cts_level)) begin
          r.tx_valid = 1'b1;
          r.tx_byte = ring[rd_ptr];
          rd_ptr = rd_ptr + 8'd1;
        end
      end
      OP_RECEIVE: begin
        if (it.data_byte == CTRL_C) begin
          r.rx_interrupt = 1'b1;
        end else if (mode == MODE_XON_NORMAL) begin
          if (!xon && it.data_byte == XON_CHAR) xon = 1'b1;
          else if (xon && it.data_byte == XOFF_CHAR) xon = 1'b0;
        end else if (mode == MODE_AUTOOFF || mode == MODE_MANUAL) begin
          xon = !xon && it.data_byte == XON_CHAR;
        end
      end
      OP_CLEAR: wr_ptr = rd_ptr;
      OP_SET_XON: xon = it.data_byte[0];
      default: ;
    endcase
    r.free_count = 8'd255 - (wr_ptr - rd_ptr);
    r.xon_now = xon;
    r.halted = !send_ok(it.cts_level);
    r.cancelled = mode == MODE_RTS_CTS && it.cts_level != cts_act;
    return r;
  endfunction

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // sample transfers and config writes, and check results
  always @(posedge clk) begin
    tx_status_t want;
    item_t it;
    if (rst) begin
      in_taken <= 1'b0;
      rd_ptr = '0;
      wr_ptr = '0;
      xon = 1'b1;
      mode = MODE_DISABLED;
      cts_act = 1'b0;
    end else begin
      in_taken <= in_valid && !in_stall;
      if (cfg_write) begin
        case (cfg_index)
          REG_FLOW_MODE: mode = cfg_data;
          REG_CTS_LEVEL: cts_act = cfg_data[0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (tx_expect_q.size() == 0) begin
          $error("result with no item pending");
          errors++;
        end else begin
          want = tx_expect_q.pop_front();
          check_field("tx_valid", want.tx_valid, tx_valid);
          check_field("tx_byte", want.tx_byte, tx_byte);
          check_field("accepted", want.accepted, accepted);
          check_field("free_count", want.free_count, free_count);
          check_field("xon_now", want.xon_now, xon_now);
          check_field("halted", want.halted, halted);
          check_field("cancelled", want.cancelled, cancelled);
          check_field("rx_interrupt", want.rx_interrupt, rx_interrupt);
        end
      end
      if (in_valid && !in_stall) begin
        it = '{op: op, data_byte: data_byte, cts_level: cts_level,
               tx_room: tx_room, tx_empty: tx_empty, rx_idle: rx_idle};
        tx_expect_q.push_back(step_tx_queue(it));
        items_taken++;
      end
    end
  end

  // sender: hold a stalled item, otherwise offer the next one or idle
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!(in_valid && !in_taken)) begin
      if (send_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        drive_item = send_q.pop_front();
        in_valid <= 1'b1;
        op <= drive_item.op;
        data_byte <= drive_item.data_byte;
        cts_level <= drive_item.cts_level;
        tx_room <= drive_item.tx_room;
        tx_empty <= drive_item.tx_empty;
        rx_idle <= drive_item.rx_idle;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus requested long hold-offs
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (holds_done < holds_wanted) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_LEN;
      holds_done <= holds_done + 1;
    end else begin
      out_stall <= $urandom_range(99) < recv_idle_pct;
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic queue_item(logic [2:0] o, logic [7:0] d, logic c, logic room,
                            logic lempty, logic ridle);
    send_q.push_back('{op: o, data_byte: d, cts_level: c, tx_room: room,
                       tx_empty: lempty, rx_idle: ridle});
    items_queued++;
  endtask

  task automatic queue_random(int count);
    int unsigned pick;
    logic [2:0] o;
    logic [7:0] d;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      d = 8'($urandom);
      if (pick < 40) o = OP_ENQUEUE;
      else if (pick < 70) o = OP_DRAIN;
      else if (pick < 84) o = OP_RECEIVE;
      else if (pick < 88) o = OP_CLEAR;
      else if (pick < 95) o = OP_SET_XON;
      else o = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
      if (o == OP_RECEIVE) begin
        case ($urandom_range(3))
          0: d = CTRL_C;
          1: d = XON_CHAR;
          2: d = XOFF_CHAR;
          default: ;
        endcase
      end
      queue_item(o, d, 1'($urandom_range(1)), $urandom_range(3) != 0,
                 $urandom_range(3) != 0, $urandom_range(3) != 0);
    end
  endtask

  // wait until every queued item is taken and every result has come
  task automatic settle();
    do @(negedge clk);
    while (items_taken != items_queued || in_valid || tx_expect_q.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic set_config(logic [2:0] m, logic lvl);
    logic [1:0] junk;
    junk = 2'($urandom_range(3));
    settle();
    write_reg(REG_FLOW_MODE, m);
    write_reg(REG_CTS_LEVEL, {junk, lvl});
    @(posedge clk);
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // pass-through, store, drain, receive codes, XON set, clear and spare ops
    queue_item(OP_ENQUEUE, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1);
    queue_item(OP_ENQUEUE, 8'hFF, 1'b1, 1'b0, 1'b0, 1'b1);
    queue_item(OP_ENQUEUE, 8'hA5, 1'b0, 1'b1, 1'b1, 1'b0);
    queue_item(OP_DRAIN, 8'h00, 1'b0, 1'b0, 1'b1, 1'b1);
    queue_item(OP_DRAIN, 8'h00, 1'b1, 1'b1, 1'b1, 1'b1);
    queue_item(OP_DRAIN, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1);
    queue_item(OP_DRAIN, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1);
    queue_item(OP_RECEIVE, CTRL_C, 1'b0, 1'b1, 1'b1, 1'b1);
    queue_item(OP_RECEIVE, XON_CHAR, 1'b0, 1'b1, 1'b1, 1'b1);
    queue_item(OP_RECEIVE, XOFF_CHAR, 1'b0, 1'b1, 1'b1, 1'b1);
    queue_item(OP_SET_XON, 8'hFE, 1'b1, 1'b1, 1'b1, 1'b1);
    queue_item(OP_SET_XON, 8'h01, 1'b0, 1'b1, 1'b1, 1'b1);
    queue_item(OP_ENQUEUE, 8'h5A, 1'b0, 1'b0, 1'b1, 1'b1);
    queue_item(OP_CLEAR, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1);
    queue_item(OP_SPARE_LO, 8'h11, 1'b1, 1'b0, 1'b0, 1'b0);
    queue_item(OP_SPARE_HI, 8'hFF, 1'b0, 1'b1, 1'b1, 1'b1);
    queue_random(20);

    set_config(MODE_RTS_CTS, 1'b0);
    queue_random(25);

    set_config(MODE_RTS_CTS, 1'b1);
    queue_item(OP_ENQUEUE, 8'h3C, 1'b0, 1'b1, 1'b1, 1'b1);
    queue_item(OP_DRAIN, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1);
    queue_item(OP_DRAIN, 8'h00, 1'b1, 1'b1, 1'b1, 1'b1);
    queue_random(25);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_config(MODE_XON_NORMAL, 1'b1);
    queue_random(30);
    settle();
    send_idle_pct = 38;
    recv_idle_pct = 38;

    // fill to overflow while the receiver holds off
    set_config(MODE_AUTOOFF, 1'b0);
    queue_item(OP_SET_XON, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1);
    for (int i = 0; i < DEPTH + 2; i++) begin
      queue_item(OP_ENQUEUE, 8'($urandom), 1'($urandom_range(1)), 1'b1, 1'b1, 1'b1);
    end
    holds_wanted++;
    settle();
    queue_item(OP_SET_XON, 8'h01, 1'b0, 1'b1, 1'b1, 1'b1);
    queue_item(OP_RECEIVE, XON_CHAR, 1'b0, 1'b1, 1'b1, 1'b1);
    queue_random(20);

    set_config(MODE_MANUAL, 1'b1);
    queue_random(15);
    settle();
    @(posedge clk);
    queue_random(10);

    set_config(MODE_SPARE_HI, 1'b0);
    queue_random(10);

    set_config(MODE_SPARE_LO, 1'b1);
    queue_random(10);

    set_config(MODE_DISABLED, 1'b0);
    queue_random(10);

    settle();
    repeat (5) @(negedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
